// ===== design/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker package
// Shared constants, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned MAX_ENTITIES = 16;
  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned MARGIN_BITS  = VALUE_BITS + 1;
  localparam int unsigned IDX_W        = $clog2(MAX_ENTITIES);
  // Loop counters hold the entity count itself, so they carry one extra bit.
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned ADDR_W       = 2 * IDX_W;
  localparam int unsigned MEM_DEPTH    = MAX_ENTITIES * MAX_ENTITIES;
  localparam int unsigned ECOUNT_W     = 5;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CLASS_W      = 2;

  localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = ECOUNT_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTITY_COUNT    = CFG_IDX_W'(0),
    REG_LOGIT_THRESHOLD = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_STRONG       = 2'd0,
    CLS_MODERATE     = 2'd1,
    CLS_WEAK         = 2'd2,
    CLS_INTRANSITIVE = 2'd3
  } st_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PAIR,
    ST_PAIR_CHK,
    ST_KREAD,
    ST_KACC,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;      // store the input entry
    logic walk_clr;  // restart i and j, clear the running maxima
    logic inc_i;     // next row, j back to zero
    logic inc_j;     // next column
    logic latch_mij; // keep M[i][j], k back to zero
    logic inc_k;
    logic rd_tri;    // address the memory with M[j][k] rather than M[i][j]
    logic acc_upd;   // fold the current triple into the maxima
    logic out_load;  // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic k_end;
    logic i_eq_j;
    logic k_skip;
    logic mij_ok;
    logic out_full;
  } dp_status_t;

endpackage

// ===== design/tcc_ifs.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker channels
// Valid/ready channels for matrix loads, results and register writes.
// ----------------------------------------------------------------------------
interface tcc_in_if import tcc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [IDX_W-1:0]             row_index;
  logic [IDX_W-1:0]             col_index;
  logic signed [VALUE_BITS-1:0] entry_value;
  logic                         last_entry;

  modport source (output valid, row_index, col_index, entry_value, last_entry,
                  input ready);
  modport sink   (input valid, row_index, col_index, entry_value, last_entry,
                  output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [MARGIN_BITS-1:0] strong_margin;
  logic signed [MARGIN_BITS-1:0] moderate_margin;
  logic signed [VALUE_BITS-1:0]  weak_margin;
  logic                          any_triple;
  logic [CLASS_W-1:0]            st_class;

  modport source (output valid, strong_margin, moderate_margin, weak_margin,
                  any_triple, st_class, input ready);
  modport sink   (input valid, strong_margin, moderate_margin, weak_margin,
                  any_triple, st_class, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker controller
// Sequences entry loads, the triple walk and the hand-over of the result.
// ----------------------------------------------------------------------------
module tcc_ctrl import tcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_INIT;
      end
      ST_INIT: state_d = ST_PAIR;
      ST_PAIR: begin
        if (status_i.i_end) begin
          state_d = ST_DONE;
        end else if (!status_i.j_end && !status_i.i_eq_j) begin
          state_d = ST_PAIR_CHK;
        end
      end
      ST_PAIR_CHK: begin
        if (status_i.mij_ok) state_d = ST_KREAD;
        else state_d = ST_PAIR;
      end
      ST_KREAD: begin
        if (status_i.k_end) begin
          state_d = ST_PAIR;
        end else if (!status_i.k_skip) begin
          state_d = ST_KACC;
        end
      end
      ST_KACC: state_d = ST_KREAD;
      ST_DONE: begin
        if (!status_i.out_full || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    busy_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        busy_o     = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_INIT: cmd_o.walk_clr = 1'b1;
      ST_PAIR: begin
        if (!status_i.i_end) begin
          if (status_i.j_end) begin
            cmd_o.inc_i = 1'b1;
          end else if (status_i.i_eq_j) begin
            cmd_o.inc_j = 1'b1;
          end
        end
      end
      ST_PAIR_CHK: begin
        if (status_i.mij_ok) cmd_o.latch_mij = 1'b1;
        else cmd_o.inc_j = 1'b1;
      end
      ST_KREAD: begin
        cmd_o.rd_tri = 1'b1;
        if (status_i.k_end) begin
          cmd_o.inc_j = 1'b1;
        end else if (status_i.k_skip) begin
          cmd_o.inc_k = 1'b1;
        end
      end
      ST_KACC: begin
        cmd_o.acc_upd = 1'b1;
        cmd_o.inc_k   = 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = !status_i.out_full || out_ready_i;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/tcc_dp.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker datapath
// Matrix memory, loop counters, running maxima, registers and result register.
// ----------------------------------------------------------------------------
module tcc_dp import tcc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  // entry load
  input  logic [IDX_W-1:0]              row_index_i,
  input  logic [IDX_W-1:0]              col_index_i,
  input  logic signed [VALUE_BITS-1:0]  entry_value_i,
  // register writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // result
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [MARGIN_BITS-1:0] strong_margin_o,
  output logic signed [MARGIN_BITS-1:0] moderate_margin_o,
  output logic signed [VALUE_BITS-1:0]  weak_margin_o,
  output logic                          any_triple_o,
  output logic [CLASS_W-1:0]            st_class_o
);

  // Configuration registers.
  logic [ECOUNT_W-1:0]         entity_count_q;
  logic signed [VALUE_BITS-1:0] threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entity_count_q <= ECOUNT_RESET;
      threshold_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ENTITY_COUNT:    entity_count_q <= cfg_data_i[ECOUNT_W-1:0];
        REG_LOGIT_THRESHOLD: threshold_q    <= $signed(cfg_data_i[VALUE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_eff;
  assign n_eff = (32'(entity_count_q) > MAX_ENTITIES) ? CNT_W'(MAX_ENTITIES)
                                                      : CNT_W'(entity_count_q);

  // Loop counters.
  logic [CNT_W-1:0] i_q, j_q, k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      if (cmd_i.walk_clr) begin
        i_q <= '0;
        j_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + CNT_W'(1);
        j_q <= '0;
      end else if (cmd_i.inc_j) begin
        j_q <= j_q + CNT_W'(1);
      end
      if (cmd_i.latch_mij) k_q <= '0;
      else if (cmd_i.inc_k) k_q <= k_q + CNT_W'(1);
    end
  end

  // Matrix memory: one write port for loads, two registered read ports.
  logic [VALUE_BITS-1:0]        matrix_q [MEM_DEPTH];
  logic [ADDR_W-1:0]            wr_addr, rd_addr_a, rd_addr_b;
  logic signed [VALUE_BITS-1:0] rdata_a_q, rdata_b_q;

  assign wr_addr   = {row_index_i, col_index_i};
  assign rd_addr_a = cmd_i.rd_tri ? {j_q[IDX_W-1:0], k_q[IDX_W-1:0]}
                                  : {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
  assign rd_addr_b = {k_q[IDX_W-1:0], i_q[IDX_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) matrix_q[wr_addr] <= entry_value_i;
    rdata_a_q <= $signed(matrix_q[rd_addr_a]);
    rdata_b_q <= $signed(matrix_q[rd_addr_b]);
  end

  // Triple evaluation. Port A holds M[j][k] and port B holds M[k][i].
  logic signed [VALUE_BITS-1:0]  mij_q;
  logic signed [VALUE_BITS-1:0]  hi_val, lo_val;
  logic signed [MARGIN_BITS-1:0] sum_hi, sum_lo;
  logic                          mjk_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_mij) mij_q <= rdata_a_q;
  end

  assign mjk_ok = rdata_a_q >= threshold_q;
  assign hi_val = (mij_q > rdata_a_q) ? mij_q : rdata_a_q;
  assign lo_val = (mij_q > rdata_a_q) ? rdata_a_q : mij_q;
  assign sum_hi = MARGIN_BITS'(rdata_b_q) + MARGIN_BITS'(hi_val);
  assign sum_lo = MARGIN_BITS'(rdata_b_q) + MARGIN_BITS'(lo_val);

  // Running maxima; cleared to zero so that an empty walk reports zeros.
  logic signed [MARGIN_BITS-1:0] strong_q, moderate_q;
  logic signed [VALUE_BITS-1:0]  weak_q;
  logic                          found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      strong_q   <= '0;
      moderate_q <= '0;
      weak_q     <= '0;
    end else if (cmd_i.walk_clr) begin
      found_q    <= 1'b0;
      strong_q   <= '0;
      moderate_q <= '0;
      weak_q     <= '0;
    end else if (cmd_i.acc_upd && mjk_ok) begin
      found_q <= 1'b1;
      if (!found_q || sum_hi > strong_q)    strong_q   <= sum_hi;
      if (!found_q || sum_lo > moderate_q)  moderate_q <= sum_lo;
      if (!found_q || rdata_b_q > weak_q)   weak_q     <= rdata_b_q;
    end
  end

  st_class_e class_d;

  always_comb begin
    if (!found_q || strong_q <= 0) begin
      class_d = CLS_STRONG;
    end else if (moderate_q <= 0) begin
      class_d = CLS_MODERATE;
    end else if (weak_q <= 0) begin
      class_d = CLS_WEAK;
    end else begin
      class_d = CLS_INTRANSITIVE;
    end
  end

  // Result register; it holds while the sink stalls.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      strong_margin_o   <= strong_q;
      moderate_margin_o <= moderate_q;
      weak_margin_o     <= weak_q;
      any_triple_o      <= found_q;
      st_class_o        <= class_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.i_end    = i_q >= n_eff;
  assign status_o.j_end    = j_q >= n_eff;
  assign status_o.k_end    = k_q >= n_eff;
  assign status_o.i_eq_j   = i_q == j_q;
  assign status_o.k_skip   = (k_q == i_q) || (k_q == j_q);
  assign status_o.mij_ok   = rdata_a_q >= threshold_q;
  assign status_o.out_full = out_valid_q;

endmodule

// ===== design/transitivity_class_checker.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker
// Loads a match-up matrix and classifies its stochastic transitivity.
// ----------------------------------------------------------------------------
// Each load transfer writes one matrix entry, so entries stream in back to
// back. The transfer marked as last is stored and then starts the triple
// walk, during which no load is taken: the walk reads the matrix memory
// over its two read ports. Each off-diagonal (i, j) pair is read and checked
// against the threshold. For a qualifying pair the walk skips each k equal
// to i or j, reads each other k and folds that triple into the maxima if
// M[j][k] meets the threshold, then closes the k loop. A diagonal pair or
// the end of a row is stepped over. The walk hands its result to the output
// register once that register is free; the result then sits there, so loads
// for the next matrix are accepted while it waits to be taken.

module transitivity_class_checker import tcc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o,
  tcc_cfg_if.sink   cfg_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy;

  assign cfg_i.ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_entry),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  tcc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .row_index_i       (in_i.row_index),
    .col_index_i       (in_i.col_index),
    .entry_value_i     (in_i.entry_value),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .strong_margin_o   (out_o.strong_margin),
    .moderate_margin_o (out_o.moderate_margin),
    .weak_margin_o     (out_o.weak_margin),
    .any_triple_o      (out_o.any_triple),
    .st_class_o        (out_o.st_class)
  );

  // A last transfer starts the walk, which closes the load side.
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_entry) |=> (!in_i.ready && busy))
    else $error("load side still open after the last entry");

  // An empty walk reports zero margins and the strong class.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.any_triple) |->
      (out_o.strong_margin == '0 && out_o.moderate_margin == '0 &&
       out_o.weak_margin == '0 && out_o.st_class == CLS_STRONG))
    else $error("empty walk gave a non-zero result");

  // The intransitive class needs every margin above zero.
  a_intransitive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.st_class == CLS_INTRANSITIVE) |->
      (out_o.weak_margin > 0 && out_o.moderate_margin > 0 &&
       out_o.strong_margin > 0))
    else $error("intransitive class with a margin at or below zero");

  // A new result only appears when the walk has finished.
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(busy))
    else $error("result raised while the block was idle");

endmodule

// ===== sim/tcc_result_checker.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker result checker
// Watches the load, result and register channels, predicts the margins and
// class of every evaluation and compares them with the results of the block.
// ----------------------------------------------------------------------------
module tcc_result_checker import tcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcc_in_if           load_mon,
  tcc_out_if          result_mon,
  tcc_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [MARGIN_BITS-1:0] strong_margin;
    logic signed [MARGIN_BITS-1:0] moderate_margin;
    logic signed [VALUE_BITS-1:0]  weak_margin;
    logic                          any_triple;
    st_class_e                     st_class;
  } verdict_t;

  logic signed [VALUE_BITS-1:0] entries [MAX_ENTITIES][MAX_ENTITIES];
  logic [ECOUNT_W-1:0]          n_entities;
  logic signed [VALUE_BITS-1:0] threshold;
  verdict_t                     verdict_q [$];
  int unsigned                  fail_count;

  // Walks every ordered triple of distinct indices and folds the qualifying
  // ones into the three running maxima.
  function automatic verdict_t walk_triples();
    int       n;
    int       thr;
    int       mij;
    int       mjk;
    int       mki;
    int       hi;
    int       lo;
    int       best_s;
    int       best_m;
    int       best_w;
    bit       found;
    verdict_t v;
    n = (n_entities > MAX_ENTITIES) ? MAX_ENTITIES : int'(n_entities);
    thr = int'(threshold);
    found = 1'b0;
    best_s = 0;
    best_m = 0;
    best_w = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i == j) continue;
        mij = int'(entries[i][j]);
        if (mij < thr) continue;
        for (int k = 0; k < n; k++) begin
          if (k == i || k == j) continue;
          mjk = int'(entries[j][k]);
          if (mjk < thr) continue;
          mki = int'(entries[k][i]);
          hi = (mij > mjk) ? mij : mjk;
          lo = (mij > mjk) ? mjk : mij;
          if (!found) begin
            best_s = mki + hi;
            best_m = mki + lo;
            best_w = mki;
            found = 1'b1;
          end else begin
            if (mki + hi > best_s) best_s = mki + hi;
            if (mki + lo > best_m) best_m = mki + lo;
            if (mki > best_w) best_w = mki;
          end
        end
      end
    end
    // With no triple the margins stand for minus infinity, which classes as strong.
    if (!found || best_s <= 0) v.st_class = CLS_STRONG;
    else if (best_m <= 0)      v.st_class = CLS_MODERATE;
    else if (best_w <= 0)      v.st_class = CLS_WEAK;
    else                       v.st_class = CLS_INTRANSITIVE;
    v.strong_margin   = found ? MARGIN_BITS'(best_s) : '0;
    v.moderate_margin = found ? MARGIN_BITS'(best_m) : '0;
    v.weak_margin     = found ? VALUE_BITS'(best_w) : '0;
    v.any_triple      = found;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      n_entities = ECOUNT_RESET;
      threshold  = '0;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      // The result is taken first: it can only stem from an earlier transfer.
      if (result_mon.valid && result_mon.ready) begin
        got = '{strong_margin:   result_mon.strong_margin,
                moderate_margin: result_mon.moderate_margin,
                weak_margin:     result_mon.weak_margin,
                any_triple:      result_mon.any_triple,
                st_class:        st_class_e'(result_mon.st_class)};
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result with nothing expected: strong %0d moderate %0d weak %0d any %0b class %0d",
                     got.strong_margin, got.moderate_margin, got.weak_margin,
                     got.any_triple, got.st_class);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("result mismatch: expected strong %0d moderate %0d weak %0d any %0b class %0d, got strong %0d moderate %0d weak %0d any %0b class %0d",
                       want.strong_margin, want.moderate_margin, want.weak_margin,
                       want.any_triple, want.st_class,
                       got.strong_margin, got.moderate_margin, got.weak_margin,
                       got.any_triple, got.st_class);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_ENTITY_COUNT:    n_entities = cfg_mon.data[ECOUNT_W-1:0];
          REG_LOGIT_THRESHOLD: threshold  = cfg_mon.data;
          default: ;
        endcase
      end
      if (load_mon.valid && load_mon.ready) begin
        entries[load_mon.row_index][load_mon.col_index] = load_mon.entry_value;
        if (load_mon.last_entry) verdict_q.push_back(walk_triples());
      end
    end
    fail_count_o <= fail_count;
    waiting_o    <= verdict_q.size();
  end

endmodule

// ===== sim/tb_transitivity_class_checker.sv =====
// ----------------------------------------------------------------------------
// Transitivity class checker testbench
// Loads match-up matrices under a range of entity counts and thresholds, with
// random gaps on both sides and a long result stall, and gives the verdict
// from the failure count of the result checker.
// ----------------------------------------------------------------------------
module tb_transitivity_class_checker import tcc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET    = 1750;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned HOLD_PHASE     = 3;
  localparam int unsigned CALM_PHASE     = 6;
  localparam int unsigned IDLE_PERCENT   = 34;

  typedef enum int {VAL_WIDE, VAL_NEAR, VAL_EDGE} value_style_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned waiting;
  int unsigned items_sent = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done  = 0;
  bit          calm       = 1'b0;
  int          thr_now    = 0;

  tcc_in_if  load_ch ();
  tcc_out_if result_ch ();
  tcc_cfg_if cfg_ch ();

  transitivity_class_checker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (load_ch),
    .out_o  (result_ch),
    .cfg_i  (cfg_ch)
  );

  tcc_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_mon     (load_ch),
    .result_mon   (result_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [VALUE_BITS-1:0] pick_value(value_style_e style);
    int v;
    case (style)
      VAL_WIDE: v = int'($urandom_range(65535)) - 32768;
      VAL_NEAR: v = thr_now + int'($urandom_range(600)) - 300;
      default: begin
        case ($urandom_range(5))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = thr_now;
          3:       v = thr_now - 1;
          4:       v = 0;
          default: v = -1;
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return VALUE_BITS'(v);
  endfunction

  // Leaves valid high after the transfer so that back-to-back loads need no
  // second assignment in the same step.
  task automatic send_load(int row, int col, logic [VALUE_BITS-1:0] value, bit last);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      load_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    load_ch.valid       <= 1'b1;
    load_ch.row_index   <= IDX_W'(row);
    load_ch.col_index   <= IDX_W'(col);
    load_ch.entry_value <= value;
    load_ch.last_entry  <= last;
    do @(posedge clk_i); while (!load_ch.ready);
    items_sent++;
  endtask

  task automatic set_config(int n, int thr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_ENTITY_COUNT;
    cfg_ch.data  <= CFG_DATA_W'(n);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= REG_LOGIT_THRESHOLD;
    cfg_ch.data  <= CFG_DATA_W'(thr);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    thr_now = thr;
  endtask

  // Waits until every evaluation has delivered its result, then lets the
  // last loads retire before the registers may change.
  task automatic quiesce();
    load_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_triangle(logic [VALUE_BITS-1:0] value);
    int cnt;
    cnt = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r != c) begin
          cnt++;
          send_load(r, c, value, cnt == 6);
        end
      end
    end
  endtask

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_asked) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((load_ch.valid && load_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int           phase;
    int           big_left;
    int           roll;
    int           n_sel;
    int           n_eff;
    int           span;
    int           thr_sel;
    int           seqs;
    int           cnt;
    value_style_e style;
    rst_ni              <= 1'b0;
    load_ch.valid       <= 1'b0;
    load_ch.row_index   <= '0;
    load_ch.col_index   <= '0;
    load_ch.entry_value <= '0;
    load_ch.last_entry  <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_ENTITY_COUNT;
    cfg_ch.data         <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The whole store is written once under the reset settings, so no later
    // walk can read an entry that was never loaded.
    for (int r = 0; r < MAX_ENTITIES; r++)
      for (int c = 0; c < MAX_ENTITIES; c++)
        send_load(r, c, pick_value(VAL_WIDE), r == MAX_ENTITIES - 1 && c == MAX_ENTITIES - 1);
    quiesce();

    // Lowest threshold with the most negative entries: every triple qualifies.
    set_config(3, -32768);
    load_triangle(16'sh8000);
    quiesce();
    // Highest threshold with the largest entries, then one entry just below it.
    set_config(3, 32767);
    load_triangle(16'sh7FFF);
    send_load(0, 1, 16'sh7FFE, 1'b1);
    quiesce();
    // A single triple whose margins give the moderate and then the weak class.
    set_config(3, 0);
    send_load(0, 1, 16'sd256, 1'b0);
    send_load(1, 2, 16'sd100, 1'b0);
    send_load(2, 0, -16'sd200, 1'b0);
    send_load(1, 0, -16'sd1, 1'b0);
    send_load(2, 1, -16'sd1, 1'b0);
    send_load(0, 2, -16'sd1, 1'b1);
    send_load(1, 2, 16'sd256, 1'b1);
    quiesce();
    // Entity counts too small for any triple.
    set_config(2, 0);
    send_load(0, 0, 16'sd0, 1'b1);
    quiesce();
    set_config(0, 0);
    send_load(15, 15, 16'sh7FFF, 1'b1);
    quiesce();
    // A count above the store size is clipped to the full matrix.
    set_config(31, -32768);
    send_load(15, 0, 16'sh8000, 1'b1);
    quiesce();

    phase = 0;
    big_left = 3;
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (phase == HOLD_PHASE) begin
        n_sel = 3;
      end else if (roll < 4 && big_left > 0) begin
        n_sel = (roll < 2) ? MAX_ENTITIES : $urandom_range(17, 31);
        big_left--;
      end else if (roll < 10) begin
        n_sel = $urandom_range(0, 2);
      end else if (roll < 30) begin
        n_sel = $urandom_range(6, 9);
      end else begin
        n_sel = $urandom_range(3, 5);
      end
      n_eff = (n_sel > MAX_ENTITIES) ? MAX_ENTITIES : n_sel;
      span = (n_eff < 2) ? MAX_ENTITIES : n_eff;

      roll = $urandom_range(99);
      if (roll < 40)      thr_sel = int'($urandom_range(512)) - 256;
      else if (roll < 60) thr_sel = 0;
      else if (roll < 80) thr_sel = int'($urandom_range(65535)) - 32768;
      else if (roll < 90) thr_sel = -32768;
      else                thr_sel = 32767;
      set_config(n_sel, thr_sel);

      style = value_style_e'($urandom_range(2));
      calm = (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) hold_asked++;
      if (n_eff == MAX_ENTITIES)   seqs = 2;
      else if (phase == HOLD_PHASE) seqs = 12;
      else                          seqs = $urandom_range(3, 8);

      for (int s = 0; s < seqs; s++) begin
        roll = $urandom_range(99);
        if (roll < 15) begin
          // Stray loads with no evaluation behind them.
          cnt = $urandom_range(1, 5);
          repeat (cnt)
            send_load($urandom_range(MAX_ENTITIES - 1), $urandom_range(MAX_ENTITIES - 1),
                      pick_value(style), 1'b0);
        end else if (roll < 50 && n_eff >= 3 && n_eff < MAX_ENTITIES) begin
          for (int r = 0; r < n_eff; r++)
            for (int c = 0; c < n_eff; c++)
              send_load(r, c, pick_value(style), r == n_eff - 1 && c == n_eff - 1);
        end else begin
          cnt = $urandom_range(1, 6);
          for (int q = 0; q < cnt; q++)
            send_load($urandom_range(span - 1), $urandom_range(span - 1),
                      pick_value(style), q == cnt - 1);
        end
      end
      quiesce();
      phase++;
    end
    calm = 1'b0;

    quiesce();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && waiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
